/* rtl/core/cursor_list_engine_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the cursor list engine
// Shared property forms used by the concurrent checks of the design.
// ---------------------------------------------------------------------------
`ifndef CURSOR_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cursor list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cursor list engine check failed");

`endif

/* rtl/core/cle_pkg.sv */
// ---------------------------------------------------------------------------
// cle_pkg
// Types, codes and defaults shared by the cursor list engine modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	localparam int CLE_DEPTH     = 32;
	localparam int CLE_WORD_BITS = 32;

	typedef enum logic [2:0] {
		OP_START          = 3'd0,
		OP_END            = 3'd1,
		OP_ADVANCE        = 3'd2,
		OP_INSERT         = 3'd3,
		OP_ATTACH         = 3'd4,
		OP_INSERT_FRONT   = 3'd5,
		OP_REMOVE_CURRENT = 3'd6,
		OP_REMOVE_FRONT   = 3'd7
	} cle_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NO_ITEM = 2'd2
	} cle_status_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] value;
	} cle_cmd_t;

	typedef struct packed {
		logic [31:0] current_value;
		logic        cursor_valid;
		logic [5:0]  count;
		logic [5:0]  cursor_pos;
		logic [1:0]  status;
	} cle_res_t;

	typedef struct packed {
		logic take_word;
		logic take_prev;
		logic take_next;
	} cle_cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/cle_cell.sv */
// ---------------------------------------------------------------------------
// cle_cell
// One list slot: holds a word, or takes the new word or a neighbor's word.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_cell #(
	parameter int WORD_BITS = cle_pkg::CLE_WORD_BITS
) (
	input  wire                      clk,
	input  cle_pkg::cle_cell_ctl_t   ctl,
	input  wire  [WORD_BITS-1:0]     word,
	input  wire  [WORD_BITS-1:0]     prev_word,
	input  wire  [WORD_BITS-1:0]     next_word,
	output logic [WORD_BITS-1:0]     stored
);

	logic [WORD_BITS-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.take_word) begin
			data_q <= word;
		end else if (ctl.take_prev) begin
			data_q <= prev_word;
		end else if (ctl.take_next) begin
			data_q <= next_word;
		end
	end

	assign stored = data_q;

endmodule

`default_nettype wire

/* rtl/core/cle_ctrl.sv */
// ---------------------------------------------------------------------------
// cle_ctrl
// Holds fill and cursor, decodes each operation and steers the cell row.
// ---------------------------------------------------------------------------
`default_nettype none

module cle_ctrl #(
	parameter int DEPTH = cle_pkg::CLE_DEPTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         fire,
	input  cle_pkg::cle_op_t            op,
	output logic [$clog2(DEPTH+1)-1:0]  fill,
	output logic [$clog2(DEPTH+1)-1:0]  cursor,
	output cle_pkg::cle_status_t        status_nx,
	output cle_pkg::cle_cell_ctl_t      cell_ctl [DEPTH]
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] fill_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] fill_nx;
	logic [CW-1:0] cursor_nx;
	logic [CW-1:0] pos;
	logic          open_gap;
	logic          close_gap;
	logic          cur_valid;
	logic          full;

	assign cur_valid = cursor_q < fill_q;
	assign full      = fill_q == CW'(DEPTH);

	always_comb begin
		fill_nx   = fill_q;
		cursor_nx = cursor_q;
		status_nx = cle_pkg::ST_OK;
		pos       = '0;
		open_gap  = 1'b0;
		close_gap = 1'b0;
		case (op)
			cle_pkg::OP_START: begin
				cursor_nx = '0;
			end
			cle_pkg::OP_END: begin
				if (fill_q != '0) begin
					cursor_nx = fill_q - 1'b1;
				end
			end
			cle_pkg::OP_ADVANCE: begin
				if (cur_valid) begin
					cursor_nx = cursor_q + 1'b1;
				end else begin
					status_nx = cle_pkg::ST_NO_ITEM;
				end
			end
			cle_pkg::OP_INSERT, cle_pkg::OP_ATTACH, cle_pkg::OP_INSERT_FRONT: begin
				if (full) begin
					status_nx = cle_pkg::ST_FULL;
				end else begin
					if (op == cle_pkg::OP_INSERT) begin
						pos = cur_valid ? cursor_q : '0;
					end else if (op == cle_pkg::OP_ATTACH) begin
						pos = cur_valid ? cursor_q + 1'b1 : fill_q;
					end else begin
						pos = '0;
					end
					open_gap  = 1'b1;
					fill_nx   = fill_q + 1'b1;
					cursor_nx = pos;
				end
			end
			cle_pkg::OP_REMOVE_CURRENT: begin
				if (cur_valid) begin
					pos       = cursor_q;
					close_gap = 1'b1;
					fill_nx   = fill_q - 1'b1;
				end else begin
					status_nx = cle_pkg::ST_NO_ITEM;
				end
			end
			cle_pkg::OP_REMOVE_FRONT: begin
				if (cur_valid) begin
					pos       = '0;
					close_gap = 1'b1;
					fill_nx   = fill_q - 1'b1;
					cursor_nx = '0;
				end else begin
					status_nx = cle_pkg::ST_NO_ITEM;
				end
			end
			default: begin
				status_nx = cle_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].take_word = fire && open_gap && (CW'(i) == pos);
			cell_ctl[i].take_prev = fire && open_gap && (CW'(i) > pos);
			cell_ctl[i].take_next = fire && close_gap && (CW'(i) >= pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cursor_q <= '0;
		end else if (fire) begin
			fill_q   <= fill_nx;
			cursor_q <= cursor_nx;
		end
	end

	assign fill   = fill_q;
	assign cursor = cursor_q;

endmodule

`default_nettype wire

/* rtl/core/cursor_list_engine.sv */
// ---------------------------------------------------------------------------
// cursor_list_engine
// Bounded ordered list with a cursor, held in a row of shifting cells.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              word
//  cmd      in         cmd_valid / cmd_ready  cle_cmd_t (op, value)
//  res      out        res_valid / res_ready  cle_res_t (one per command)
//
// One command per cycle is accepted.
// The cell row shifts around the insertion or removal point in the cycle
// a command is accepted, and the entry at the cursor is then read into
// the result register once it is free. A stalled result stops intake
// once the single result stage behind the cells is also occupied.
// Reset clears fill and cursor; list entries need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module cursor_list_engine #(
	parameter int DEPTH     = cle_pkg::CLE_DEPTH,
	parameter int WORD_BITS = cle_pkg::CLE_WORD_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	output logic              cmd_ready,
	input  cle_pkg::cle_cmd_t cmd,
	output logic              res_valid,
	input  wire               res_ready,
	output cle_pkg::cle_res_t res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic                   fire;
	logic                   out_free;
	logic [WORD_BITS-1:0]   word;
	logic [WORD_BITS-1:0]   cells [DEPTH];
	logic [CW-1:0]          fill;
	logic [CW-1:0]          cursor;
	logic                   cur_valid;
	cle_pkg::cle_status_t   status_nx;
	cle_pkg::cle_cell_ctl_t cell_ctl [DEPTH];

	logic                   busy_s1;
	cle_pkg::cle_status_t   status_s1;
	logic                   res_valid_q;
	cle_pkg::cle_res_t      res_q;
	cle_pkg::cle_res_t      res_nx;

	assign out_free  = !res_valid_q || res_ready;
	assign cmd_ready = !busy_s1 || out_free;
	assign fire      = cmd_valid && cmd_ready;
	assign word      = WORD_BITS'(cmd.value);

	cle_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op       (cle_pkg::cle_op_t'(cmd.op)),
		.fill     (fill),
		.cursor   (cursor),
		.status_nx(status_nx),
		.cell_ctl (cell_ctl)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_BITS-1:0] prev_word;
		logic [WORD_BITS-1:0] next_word;

		if (g == 0) begin : g_first
			assign prev_word = word;
		end else begin : g_mid_prev
			assign prev_word = cells[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_word = cells[g];
		end else begin : g_mid_next
			assign next_word = cells[g+1];
		end

		cle_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[g]),
			.word     (word),
			.prev_word(prev_word),
			.next_word(next_word),
			.stored   (cells[g])
		);
	end

	assign cur_valid = cursor < fill;

	always_comb begin
		res_nx.current_value = cur_valid ? 32'(cells[cursor[IW-1:0]]) : '0;
		res_nx.cursor_valid  = cur_valid;
		res_nx.count         = 6'(fill);
		res_nx.cursor_pos    = 6'(cursor);
		res_nx.status        = status_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_s1 <= 1'b1;
			end else if (out_free) begin
				busy_s1 <= 1'b0;
			end
			if (out_free) begin
				res_valid_q <= busy_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= status_nx;
		end
		if (busy_s1 && out_free) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`include "cursor_list_engine_assert.svh"

	`CLE_ASSERT_NOW(a_cursor_in_range, clk, arst_n, 1'b1, (cursor <= fill) && (fill <= CW'(DEPTH)))
	`CLE_ASSERT_NOW(a_stall_blocks_intake, clk, arst_n, busy_s1 && res_valid_q && !res_ready, !cmd_ready)
	`CLE_ASSERT_NEXT(a_insert_grows, clk, arst_n, fire && status_nx == cle_pkg::ST_OK && (cmd.op == cle_pkg::OP_INSERT || cmd.op == cle_pkg::OP_ATTACH || cmd.op == cle_pkg::OP_INSERT_FRONT), fill == CW'($past(fill) + 1'b1))
	`CLE_ASSERT_NEXT(a_error_holds, clk, arst_n, fire && status_nx != cle_pkg::ST_OK, $stable(fill) && $stable(cursor))

endmodule

`default_nettype wire
